@@ hdl/lid_pkg.sv @@
// ----------------------------------------------------------------------------
// lid_pkg
// Shared codes, result type and decode function for the line-0 instruction
// decoder (immediate ALU ops, bit ops and MOVEP).
// ----------------------------------------------------------------------------
package lid_pkg;

    localparam int OPCODE_W = 16;

    // operation codes
    localparam logic [3:0] OP_ORI   = 4'd0;
    localparam logic [3:0] OP_ANDI  = 4'd1;
    localparam logic [3:0] OP_SUBI  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd3;
    localparam logic [3:0] OP_EORI  = 4'd4;
    localparam logic [3:0] OP_CMPI  = 4'd5;
    localparam logic [3:0] OP_BTST  = 4'd6;
    localparam logic [3:0] OP_MOVEP = 4'd10;

    // operand sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    // addressing kinds, plus two internal codes used only while decoding
    localparam logic [3:0] KIND_DN      = 4'd0;
    localparam logic [3:0] KIND_D16     = 4'd4;
    localparam logic [3:0] KIND_PCX_MAX = 4'd5;
    localparam logic [3:0] KIND_ABSW    = 4'd6;
    localparam logic [3:0] KIND_ABSL    = 4'd7;
    localparam logic [3:0] KIND_PCD     = 4'd8;
    localparam logic [3:0] KIND_PCX     = 4'd9;
    localparam logic [3:0] KIND_IMM     = 4'd10;
    localparam logic [3:0] KIND_CCR     = 4'd11;
    localparam logic [3:0] KIND_SR      = 4'd12;
    localparam logic [3:0] KIND_SPECIAL = 4'd13;
    localparam logic [3:0] KIND_BAD     = 4'd15;

    // mode field codes
    localparam logic [2:0] MODE_DN  = 3'd0;
    localparam logic [2:0] MODE_AN  = 3'd1;
    localparam logic [2:0] MODE_EXT = 3'd7;

    // static bit op and unused register X codes, plus the unused mode X code
    localparam logic [2:0] RX_STATIC = 3'd4;
    localparam logic [2:0] RX_NONE   = 3'd7;
    localparam logic [2:0] MX_NONE   = 3'd3;

    typedef struct packed {
        logic       valid_res;
        logic [3:0] operation;
        logic [1:0] size;
        logic [3:0] source_kind;
        logic [2:0] source_register;
        logic [3:0] destination_kind;
        logic [2:0] destination_register;
        logic [2:0] extension_words;
    } t_dec_res;

    // immediate ALU operation selected by register X
    function automatic logic [3:0] alu_op(input logic [2:0] rx);
        logic [3:0] op;
        unique case (rx)
            3'd0:    op = OP_ORI;
            3'd1:    op = OP_ANDI;
            3'd2:    op = OP_SUBI;
            3'd3:    op = OP_ADDI;
            3'd5:    op = OP_EORI;
            3'd6:    op = OP_CMPI;
            default: op = OP_ORI;
        endcase
        return op;
    endfunction

    // full decode of one opcode word
    function automatic t_dec_res decode(input logic [OPCODE_W-1:0] w);
        logic [2:0] rx, mx, my, ry;
        logic [3:0] kind;
        logic [2:0] aext;
        logic       ok;
        logic [3:0] op, sk, dk;
        logic [1:0] sz;
        logic [2:0] sr, dr, ext;
        t_dec_res   res;
        rx = w[11:9];
        mx = w[8:6];
        my = w[5:3];
        ry = w[2:0];
        ok = 1'b0;
        op = OP_ORI;
        sz = SZ_BYTE;
        sk = KIND_DN;
        sr = 3'd0;
        dk = KIND_DN;
        dr = 3'd0;
        ext = 3'd0;

        // classify mode Y / register Y
        aext = 3'd0;
        if (my == MODE_DN) begin
            kind = KIND_DN;
        end else if (my == MODE_AN) begin
            kind = KIND_BAD;
        end else if (my <= 3'd4) begin
            kind = {1'b0, my} - 4'd1;
        end else if (my <= 3'd6) begin
            kind = {1'b0, my} - 4'd1;
            aext = 3'd1;
        end else begin
            unique case (ry)
                3'd0: begin kind = KIND_ABSW; aext = 3'd1; end
                3'd1: begin kind = KIND_ABSL; aext = 3'd2; end
                3'd2: begin kind = KIND_PCD;  aext = 3'd1; end
                3'd3: begin kind = KIND_PCX;  aext = 3'd1; end
                3'd4: kind = KIND_SPECIAL;
                default: kind = KIND_BAD;
            endcase
        end

        if (!mx[2]) begin
            if (rx == RX_STATIC) begin
                // static bit operation, bit number in one immediate word
                op = OP_BTST + {2'b00, mx[1:0]};
                sk = KIND_IMM;
                if (kind == KIND_BAD || kind == KIND_SPECIAL) begin
                    ok = 1'b0;
                end else if ((kind == KIND_PCD || kind == KIND_PCX) && mx != 3'd0) begin
                    ok = 1'b0;
                end else begin
                    ok = 1'b1;
                end
                sz = (kind == KIND_DN) ? SZ_LONG : SZ_BYTE;
                ext = 3'd1 + aext;
                dk = kind;
            end else if (rx != RX_NONE && mx != MX_NONE) begin
                // immediate ALU operation
                op = alu_op(rx);
                sz = mx[1:0];
                sk = KIND_IMM;
                ext = ((mx == 3'd2) ? 3'd2 : 3'd1) + aext;
                dk = kind;
                if (kind == KIND_BAD || kind == KIND_PCD || kind == KIND_PCX) begin
                    ok = 1'b0;
                end else if (kind == KIND_SPECIAL) begin
                    ok = (mx < 3'd2) && (op == OP_ORI || op == OP_ANDI || op == OP_EORI);
                    dk = (mx == 3'd0) ? KIND_CCR : KIND_SR;
                end else begin
                    ok = 1'b1;
                end
            end
        end else if (my == MODE_AN) begin
            // movep between data register and d16(An)
            ok = 1'b1;
            op = OP_MOVEP;
            sz = mx[0] ? SZ_LONG : SZ_WORD;
            ext = 3'd1;
            if (!mx[1]) begin
                sk = KIND_D16; sr = ry; dk = KIND_DN;  dr = rx;
            end else begin
                sk = KIND_DN;  sr = rx; dk = KIND_D16; dr = ry;
            end
        end else begin
            // dynamic bit operation, bit number in data register X
            op = OP_BTST + {2'b00, mx[1:0]};
            sk = KIND_DN;
            sr = rx;
            dk = kind;
            ext = aext;
            sz = (kind == KIND_DN) ? SZ_LONG : SZ_BYTE;
            if (kind == KIND_BAD) begin
                ok = 1'b0;
            end else if (kind == KIND_PCD || kind == KIND_PCX) begin
                ok = (mx[1:0] == 2'd0);
            end else if (kind == KIND_SPECIAL) begin
                ok = (mx[1:0] == 2'd0);
                dk = KIND_IMM;
                ext = 3'd1;
            end else begin
                ok = 1'b1;
            end
        end

        // register-based destinations carry register Y
        if (ok && op != OP_MOVEP && dk <= KIND_PCX_MAX) begin
            dr = ry;
        end

        if (ok) begin
            res = '{valid_res: 1'b1, operation: op, size: sz, source_kind: sk,
                    source_register: sr, destination_kind: dk,
                    destination_register: dr, extension_words: ext};
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

@@ hdl/line0_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// line0_instruction_decoder
// Decodes one opcode word of the immediate / bit-op / MOVEP group into
// operation, size, operand kinds, registers and extension word count.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | start, busy, i_opcode_word                | in
//  result    | o_strobe, o_valid_res .. o_extension_words| out
//
//  one request per cycle; busy is never raised
//  path: input register, decode logic, result register
//  each result shows for one cycle with o_strobe; the receiver cannot stall
//  synchronous active-low reset clears both valid flags
module line0_instruction_decoder
    import lid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode_word,
    output logic                o_strobe,
    output logic                o_valid_res,
    output logic [3:0]          o_operation,
    output logic [1:0]          o_size,
    output logic [3:0]          o_source_kind,
    output logic [2:0]          o_source_register,
    output logic [3:0]          o_destination_kind,
    output logic [2:0]          o_destination_register,
    output logic [2:0]          o_extension_words
);

    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_word;
    logic                r_out_vld;
    t_dec_res            r_res;
    t_dec_res            n_res;

    // never holds requests off
    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start;
        end
        if (start) begin
            r_word <= i_opcode_word;
        end
    end

    // decode logic
    always_comb begin
        n_res = decode(r_word);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_strobe               = r_out_vld;
    assign o_valid_res            = r_res.valid_res;
    assign o_operation            = r_res.operation;
    assign o_size                 = r_res.size;
    assign o_source_kind          = r_res.source_kind;
    assign o_source_register      = r_res.source_register;
    assign o_destination_kind     = r_res.destination_kind;
    assign o_destination_register = r_res.destination_register;
    assign o_extension_words      = r_res.extension_words;

endmodule

@@ sim/tb_line0_instruction_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line0_instruction_decoder
// Self-checking bench for the line-0 opcode decoder. A short table of
// hand-picked opcode words runs first, some of them with hand-typed results.
// Random words follow, biased towards the special addressing forms and
// MOVEP. Each result is compared field by field with its hand-typed result
// or a behavioural decode of that word. Request gaps come in random bursts.
// ----------------------------------------------------------------------------
module tb_line0_instruction_decoder;
    import lid_pkg::*;

    localparam int RANDOM_REQUESTS = 1850;
    localparam int QUIET_TAIL      = 200;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 40;
    localparam int TABLE_ROWS      = 25;

    // register X selections of the immediate ALU group
    localparam logic [2:0] RX_ORI  = 3'd0;
    localparam logic [2:0] RX_ANDI = 3'd1;
    localparam logic [2:0] RX_SUBI = 3'd2;
    localparam logic [2:0] RX_ADDI = 3'd3;
    localparam logic [2:0] RX_EORI = 3'd5;
    localparam logic [2:0] RX_CMPI = 3'd6;

    // first mode with a displacement word, and register Y codes under mode 7
    localparam logic [2:0] MODE_AN_D16 = 3'd5;
    localparam logic [2:0] EXT_ABSW    = 3'd0;
    localparam logic [2:0] EXT_ABSL    = 3'd1;
    localparam logic [2:0] EXT_PCD     = 3'd2;
    localparam logic [2:0] EXT_PCX     = 3'd3;
    localparam logic [2:0] EXT_IMM     = 3'd4;

    // hand-typed results
    localparam t_dec_res DEC_ILLEGAL = '0;
    localparam t_dec_res DEC_ORI_B_D0 = '{valid_res: 1'b1, operation: OP_ORI, size: SZ_BYTE,
        source_kind: KIND_IMM, source_register: 3'd0, destination_kind: KIND_DN,
        destination_register: 3'd0, extension_words: 3'd1};
    localparam t_dec_res DEC_ORI_CCR = '{valid_res: 1'b1, operation: OP_ORI, size: SZ_BYTE,
        source_kind: KIND_IMM, source_register: 3'd0, destination_kind: KIND_CCR,
        destination_register: 3'd0, extension_words: 3'd1};
    localparam t_dec_res DEC_ANDI_SR = '{valid_res: 1'b1, operation: OP_ANDI, size: SZ_WORD,
        source_kind: KIND_IMM, source_register: 3'd0, destination_kind: KIND_SR,
        destination_register: 3'd0, extension_words: 3'd1};

    typedef struct packed {
        logic [15:0] word;
        logic        typed;
        t_dec_res    result;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode_word;
    logic                o_strobe;
    logic                o_valid_res;
    logic [3:0]          o_operation;
    logic [1:0]          o_size;
    logic [3:0]          o_source_kind;
    logic [2:0]          o_source_register;
    logic [3:0]          o_destination_kind;
    logic [2:0]          o_destination_register;
    logic [2:0]          o_extension_words;

    // hand-typed expectation travelling with the request
    logic     use_typed;
    t_dec_res typed_result;

    t_dec_res  pending_decodes[$];
    int        mismatches;
    int        cycles;
    t_stim_row stim_table [0:TABLE_ROWS-1];

    line0_instruction_decoder u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_opcode_word          (i_opcode_word),
        .o_strobe               (o_strobe),
        .o_valid_res            (o_valid_res),
        .o_operation            (o_operation),
        .o_size                 (o_size),
        .o_source_kind          (o_source_kind),
        .o_source_register      (o_source_register),
        .o_destination_kind     (o_destination_kind),
        .o_destination_register (o_destination_register),
        .o_extension_words      (o_extension_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // behavioural decode of one opcode word
    function automatic t_dec_res predict_decode(input logic [15:0] w);
        logic [2:0] reg_x, mode_x, mode_y, reg_y;
        logic [3:0] ea_kind;
        logic [2:0] ea_words;
        logic       is_pc;
        t_dec_res   r;
        reg_x = w[11:9];
        mode_x = w[8:6];
        mode_y = w[5:3];
        reg_y = w[2:0];
        r = '0;
        ea_words = 3'd0;

        // effective address in mode Y / register Y
        if (mode_y == MODE_DN) begin
            ea_kind = KIND_DN;
        end else if (mode_y == MODE_AN) begin
            ea_kind = KIND_BAD;
        end else if (mode_y != MODE_EXT) begin
            ea_kind = {1'b0, mode_y} - 4'd1;
            ea_words = (mode_y >= MODE_AN_D16) ? 3'd1 : 3'd0;
        end else begin
            case (reg_y)
                EXT_ABSW: begin ea_kind = KIND_ABSW; ea_words = 3'd1; end
                EXT_ABSL: begin ea_kind = KIND_ABSL; ea_words = 3'd2; end
                EXT_PCD:  begin ea_kind = KIND_PCD;  ea_words = 3'd1; end
                EXT_PCX:  begin ea_kind = KIND_PCX;  ea_words = 3'd1; end
                EXT_IMM:  ea_kind = KIND_SPECIAL;
                default:  ea_kind = KIND_BAD;
            endcase
        end
        is_pc = (ea_kind == KIND_PCD) || (ea_kind == KIND_PCX);

        if (!mode_x[2]) begin
            if (reg_x == RX_STATIC) begin
                // static bit op, bit number in an immediate word
                r.operation = OP_BTST + {2'b00, mode_x[1:0]};
                r.source_kind = KIND_IMM;
                r.size = (ea_kind == KIND_DN) ? SZ_LONG : SZ_BYTE;
                r.extension_words = 3'd1 + ea_words;
                r.destination_kind = ea_kind;
                r.valid_res = (ea_kind != KIND_BAD) && (ea_kind != KIND_SPECIAL)
                              && !(is_pc && mode_x != 3'd0);
            end else if (reg_x != RX_NONE && mode_x != MX_NONE) begin
                // immediate alu op
                case (reg_x)
                    RX_ANDI: r.operation = OP_ANDI;
                    RX_SUBI: r.operation = OP_SUBI;
                    RX_ADDI: r.operation = OP_ADDI;
                    RX_EORI: r.operation = OP_EORI;
                    RX_CMPI: r.operation = OP_CMPI;
                    default: r.operation = OP_ORI;
                endcase
                r.size = mode_x[1:0];
                r.source_kind = KIND_IMM;
                r.extension_words = ((r.size == SZ_LONG) ? 3'd2 : 3'd1) + ea_words;
                r.destination_kind = ea_kind;
                if (ea_kind == KIND_SPECIAL) begin
                    r.valid_res = (r.size != SZ_LONG) && (r.operation == OP_ORI
                                  || r.operation == OP_ANDI || r.operation == OP_EORI);
                    r.destination_kind = (r.size == SZ_BYTE) ? KIND_CCR : KIND_SR;
                end else begin
                    r.valid_res = (ea_kind != KIND_BAD) && !is_pc;
                end
            end
        end else if (mode_y == MODE_AN) begin
            // movep, direction from mode X bit 1
            r.valid_res = 1'b1;
            r.operation = OP_MOVEP;
            r.size = mode_x[0] ? SZ_LONG : SZ_WORD;
            r.extension_words = 3'd1;
            if (mode_x[1]) begin
                r.source_kind = KIND_DN;
                r.source_register = reg_x;
                r.destination_kind = KIND_D16;
                r.destination_register = reg_y;
            end else begin
                r.source_kind = KIND_D16;
                r.source_register = reg_y;
                r.destination_kind = KIND_DN;
                r.destination_register = reg_x;
            end
        end else begin
            // dynamic bit op, bit number in data register X
            r.operation = OP_BTST + {2'b00, mode_x[1:0]};
            r.source_kind = KIND_DN;
            r.source_register = reg_x;
            r.destination_kind = ea_kind;
            r.extension_words = ea_words;
            r.size = (ea_kind == KIND_DN) ? SZ_LONG : SZ_BYTE;
            if (ea_kind == KIND_SPECIAL) begin
                r.destination_kind = KIND_IMM;
                r.extension_words = 3'd1;
            end
            if (ea_kind == KIND_BAD) begin
                r.valid_res = 1'b0;
            end else if (is_pc || ea_kind == KIND_SPECIAL) begin
                r.valid_res = (mode_x[1:0] == 2'd0);
            end else begin
                r.valid_res = 1'b1;
            end
        end

        // register-based destinations carry register Y
        if (r.valid_res && r.operation != OP_MOVEP && r.destination_kind <= KIND_PCX_MAX) begin
            r.destination_register = reg_y;
        end
        if (!r.valid_res) begin
            r = '0;
        end
        return r;
    endfunction

    // random opcode word, leaning on the special forms and movep
    function automatic logic [15:0] random_opcode();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                w[5:3] = MODE_EXT;
                w[2:0] = 3'($urandom_range(0, 4));
            end
            2: w[15:12] = 4'd0;
            default: begin
                w[8] = 1'b1;
                w[5:3] = MODE_AN;
            end
        endcase
        return w;
    endfunction

    task automatic report_field(input string name, input int expd, input int actl);
        if (expd != actl) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, actl);
        end
    endtask

    // result check first, then capture of the request taken at this edge
    always @(posedge i_clk) begin
        t_dec_res oldest;
        if (i_rst_n && o_strobe) begin
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, {o_valid_res, o_operation, o_size, o_source_kind,
                             o_source_register, o_destination_kind, o_destination_register,
                             o_extension_words});
            end else begin
                oldest = pending_decodes.pop_front();
                report_field("valid_res", oldest.valid_res, o_valid_res);
                report_field("operation", oldest.operation, o_operation);
                report_field("size", oldest.size, o_size);
                report_field("source_kind", oldest.source_kind, o_source_kind);
                report_field("source_register", oldest.source_register, o_source_register);
                report_field("destination_kind", oldest.destination_kind, o_destination_kind);
                report_field("destination_register", oldest.destination_register,
                             o_destination_register);
                report_field("extension_words", oldest.extension_words, o_extension_words);
            end
        end
        if (i_rst_n && start && !busy)
            pending_decodes.push_back(use_typed ? typed_result : predict_decode(i_opcode_word));
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // present one request and hold it until taken
    task automatic issue_request(input logic [15:0] word, input logic typed, input t_dec_res r);
        logic stalled;
        start <= 1'b1;
        i_opcode_word <= word;
        use_typed <= typed;
        typed_result <= r;
        do begin
            @(negedge i_clk);
            stalled = busy;
            @(posedge i_clk);
        end while (stalled === 1'b1);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_idle(input int idx);
        if (idx < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 12));
    endtask

    initial begin
        stim_table = '{
            '{16'h0000, 1'b1, DEC_ORI_B_D0},  // all fields zero
            '{16'hFFFF, 1'b1, DEC_ILLEGAL},   // all fields ones
            '{16'h003C, 1'b1, DEC_ORI_CCR},   // ori to ccr
            '{16'h007C, 1'b0, DEC_ILLEGAL},   // ori to sr
            '{16'h027C, 1'b1, DEC_ANDI_SR},   // andi to sr
            '{16'h0A3C, 1'b0, DEC_ILLEGAL},   // eori to ccr
            '{16'h043C, 1'b1, DEC_ILLEGAL},   // subi has no ccr form
            '{16'h00BC, 1'b1, DEC_ILLEGAL},   // long size on the status form
            '{16'h0008, 1'b1, DEC_ILLEGAL},   // address register direct
            '{16'h0480, 1'b0, DEC_ILLEGAL},   // subi.l to data register
            '{16'h0679, 1'b0, DEC_ILLEGAL},   // addi.w to abs.l
            '{16'h0C3A, 1'b1, DEC_ILLEGAL},   // cmpi to pc relative
            '{16'h083A, 1'b0, DEC_ILLEGAL},   // static btst on pc relative
            '{16'h087B, 1'b1, DEC_ILLEGAL},   // static bchg on pc indexed
            '{16'h08C5, 1'b0, DEC_ILLEGAL},   // static bset on data register
            '{16'h0E00, 1'b1, DEC_ILLEGAL},   // unused register X
            '{16'h00C0, 1'b1, DEC_ILLEGAL},   // unused size
            '{16'h0108, 1'b0, DEC_ILLEGAL},   // movep.w memory to register
            '{16'h0FCF, 1'b0, DEC_ILLEGAL},   // movep.l register to memory
            '{16'h013C, 1'b0, DEC_ILLEGAL},   // dynamic btst on immediate
            '{16'h017C, 1'b1, DEC_ILLEGAL},   // dynamic bchg on immediate
            '{16'h053A, 1'b0, DEC_ILLEGAL},   // dynamic btst on pc relative
            '{16'h07BB, 1'b1, DEC_ILLEGAL},   // dynamic bclr on pc indexed
            '{16'h0DF0, 1'b0, DEC_ILLEGAL},   // dynamic bset on indexed
            '{16'hF4A8, 1'b0, DEC_ILLEGAL}    // top nibble set, subi.l d16(An)
        };
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_opcode_word <= '0;
        use_typed <= 1'b0;
        typed_result <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < TABLE_ROWS; i++) begin
            issue_request(stim_table[i].word, stim_table[i].typed, stim_table[i].result);
            if (i % 5 == 4)
                idle_for($urandom_range(1, 12));
        end

        // random words
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_decodes.size() != 0) @(posedge i_clk);
            end else begin
                maybe_idle(i);
            end
            issue_request(random_opcode(), 1'b0, DEC_ILLEGAL);
        end
        start <= 1'b0;

        // drain
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
